>>> rtl/sfl_pkg.sv
// Shared constants and types for the stereo freeze looper.
package sfl_pkg;

	localparam int LOOP_DEPTH    = 4096;
	localparam int BLOCK_SAMPLES = 128;

	localparam int SAMPLE_W = 16;
	localparam int MODE_W   = 2;
	localparam int POS_W    = 64;
	localparam int PTR_W    = $clog2(LOOP_DEPTH);
	localparam int PHASE_W  = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
	localparam int WORD_W   = 2 * SAMPLE_W;

	typedef logic [MODE_W-1:0]   mode_t;
	typedef logic [PTR_W-1:0]    ptr_t;
	typedef logic [PHASE_W-1:0]  phase_t;
	typedef logic [POS_W-1:0]    pos_t;
	typedef logic [WORD_W-1:0]   word_t;

	localparam mode_t MODE_NONE    = 2'd0;
	localparam mode_t MODE_ENABLE  = 2'd1;
	localparam mode_t MODE_DISABLE = 2'd2;
	localparam mode_t MODE_TOGGLE  = 2'd3;

endpackage

>>> rtl/sfl_in_if.sv
// Input channel: one stereo sample with freeze commands per transaction.
interface sfl_in_if
	import sfl_pkg::*;
;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] left_in;
	logic signed [SAMPLE_W-1:0] right_in;
	mode_t                      mode;
	logic                       arm_onset;
	pos_t                       onset_at;
	logic                       arm_release;
	pos_t                       release_at;

	modport source (
		output valid, left_in, right_in, mode, arm_onset, onset_at, arm_release, release_at,
		input  ready
	);
	modport sink (
		input  valid, left_in, right_in, mode, arm_onset, onset_at, arm_release, release_at,
		output ready
	);
endinterface

>>> rtl/sfl_out_if.sv
// Output channel: one stereo sample and its frozen flag per transaction.
interface sfl_out_if
	import sfl_pkg::*;
;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] left_out;
	logic signed [SAMPLE_W-1:0] right_out;
	logic                       frozen;

	modport source (
		output valid, left_out, right_out, frozen,
		input  ready
	);
	modport sink (
		input  valid, left_out, right_out, frozen,
		output ready
	);
endinterface

>>> rtl/sfl_ram.sv
// Generic simple dual-port RAM with registered read.
module sfl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

>>> rtl/stereo_audio_freeze_loop.sv
// Top level of the stereo freeze looper: control, ring buffer and output register.
//
//   channel  dir  handshake    payload
//   in_ch    in   valid/ready  left_in, right_in, mode, arm_onset, onset_at,
//                              arm_release, release_at
//   out_ch   out  valid/ready  left_out, right_out, frozen
//
// One transaction per cycle unless the output stalls; results show the next cycle.
// The single ring-buffer RAM port pair sets that rate: one write or one read per item.
// Reset clears pointers, schedule and counter; unwritten buffer entries read as zero
// through a written-once flag and the write pointer, so no clearing pass is needed.
// A stalled output holds its register and input ready drops until it is taken.
module stereo_audio_freeze_loop
	import sfl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	sfl_in_if.sink     in_ch,
	sfl_out_if.source  out_ch
);
	ptr_t   wp_q, rp_q;
	logic   freeze_q;
	logic   wrapped_q;
	pos_t   onset_q, release_q, count_q;
	phase_t phase_q;

	logic   out_valid_s1;
	logic   frozen_s1;
	logic   ent_valid_s1;
	logic [SAMPLE_W-1:0] left_s1, right_s1;

	logic   in_acc;
	logic   boundary;
	logic   onset_fire, release_fire;
	logic   freeze_n;
	ptr_t   rp_n;
	pos_t   onset_n, release_n;
	pos_t   onset_a, release_a;
	ptr_t   wp_adv, rp_adv;
	logic   ram_we, ram_re;
	word_t  ram_rdata;

	function automatic logic in_block(input pos_t target, input pos_t count);
		logic [POS_W:0] diff;
		diff = {1'b0, target} - {1'b0, count};
		return (target != '0) && !diff[POS_W] && (diff[POS_W-1:0] < POS_W'(BLOCK_SAMPLES));
	endfunction

	assign in_ch.ready = !out_valid_s1 || out_ch.ready;
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign boundary    = (phase_q == '0);

	assign onset_a   = in_ch.arm_onset ? in_ch.onset_at : onset_q;
	assign release_a = in_ch.arm_release ? in_ch.release_at : release_q;

	assign onset_fire   = boundary && in_block(onset_a, count_q);
	assign release_fire = boundary && in_block(release_a, count_q);

	always_comb begin
		freeze_n  = freeze_q;
		rp_n      = rp_q;
		onset_n   = onset_a;
		release_n = release_a;
		unique case (in_ch.mode)
			MODE_ENABLE: begin
				freeze_n = 1'b1;
				rp_n     = wp_q;
			end
			MODE_DISABLE: begin
				freeze_n = 1'b0;
			end
			MODE_TOGGLE: begin
				if (freeze_q) begin
					freeze_n = 1'b0;
				end else begin
					freeze_n = 1'b1;
					rp_n     = wp_q;
				end
			end
			default: begin
			end
		endcase
		if (onset_fire) begin
			freeze_n = 1'b1;
			rp_n     = wp_q;
			onset_n  = '0;
		end
		if (release_fire) begin
			freeze_n  = 1'b0;
			release_n = '0;
		end
	end

	assign wp_adv = (wp_q == PTR_W'(LOOP_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign rp_adv = (rp_n == PTR_W'(LOOP_DEPTH - 1)) ? '0 : rp_n + 1'b1;

	assign ram_we = in_acc && !freeze_n;
	assign ram_re = in_acc && freeze_n;

	sfl_ram #(
		.WIDTH (WORD_W),
		.DEPTH (LOOP_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata ({in_ch.left_in, in_ch.right_in}),
		.re    (ram_re),
		.raddr (rp_n),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q         <= '0;
			rp_q         <= '0;
			freeze_q     <= 1'b0;
			wrapped_q    <= 1'b0;
			onset_q      <= '0;
			release_q    <= '0;
			count_q      <= '0;
			phase_q      <= '0;
			out_valid_s1 <= 1'b0;
		end else begin
			if (in_acc) begin
				freeze_q  <= freeze_n;
				onset_q   <= onset_n;
				release_q <= release_n;
				count_q   <= count_q + 1'b1;
				phase_q   <= (phase_q == PHASE_W'(BLOCK_SAMPLES - 1)) ? '0 : phase_q + 1'b1;
				if (freeze_n) begin
					rp_q <= rp_adv;
				end else begin
					rp_q <= rp_n;
					wp_q <= wp_adv;
					if (wp_q == PTR_W'(LOOP_DEPTH - 1)) begin
						wrapped_q <= 1'b1;
					end
				end
				out_valid_s1 <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			frozen_s1    <= freeze_n;
			ent_valid_s1 <= wrapped_q || (rp_n < wp_q);
			left_s1      <= in_ch.left_in;
			right_s1     <= in_ch.right_in;
		end
	end

	assign out_ch.valid     = out_valid_s1;
	assign out_ch.frozen    = frozen_s1;
	assign out_ch.left_out  = $signed(!frozen_s1 ? left_s1 :
		(ent_valid_s1 ? ram_rdata[WORD_W-1:SAMPLE_W] : SAMPLE_W'(0)));
	assign out_ch.right_out = $signed(!frozen_s1 ? right_s1 :
		(ent_valid_s1 ? ram_rdata[SAMPLE_W-1:0] : SAMPLE_W'(0)));

`ifndef SYNTHESIS
	a_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("buffer written and read by one transaction");

	a_wp_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wp_q < PTR_W'(LOOP_DEPTH - 1)) || (wp_q == PTR_W'(LOOP_DEPTH - 1)))
		else $error("write pointer beyond buffer");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (count_q == $past(count_q) + 1'b1))
		else $error("sample count did not advance");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s1 && !out_ch.ready) |-> !in_ch.ready)
		else $error("input accepted while result stalled");

	a_freeze_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_acc |=> ($stable(freeze_q) && $stable(wp_q) && $stable(rp_q)))
		else $error("loop state moved without a transaction");
`endif
endmodule
